[src/gpm_pkg.sv]
package gpm_pkg;

   typedef enum logic [2:0] {
      ACT_NEW_PATTERN      = 3'd0,
      ACT_PATTERN_BYTE     = 3'd1,
      ACT_PATTERN_ABSENT   = 3'd2,
      ACT_VALUE_BYTE       = 3'd3,
      ACT_EVALUATE         = 3'd4,
      ACT_EVALUATE_ABSENT  = 3'd5
   } action_type;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_DASH  = 8'h2D;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_EVAL_START,
      OP_STAR,
      OP_ADV,
      OP_BACK,
      OP_SKIP,
      OP_RESULT,
      OP_CLS_START,
      OP_CLS_INV,
      OP_CLS_CLOSE,
      OP_CLS_LO,
      OP_CLS_SINGLE,
      OP_CLS_RANGE,
      OP_CLS_TAKE,
      OP_CLS_LIT
   } op_type;

   typedef enum logic [1:0] {
      PSEL_PI,
      PSEL_CI,
      PSEL_CI1,
      PSEL_CI2
   } psel_type;

   typedef struct packed {
      op_type   op;
      psel_type psel;
      logic     res;
   } cmd_type;

   typedef struct packed {
      logic quick;
      logic quick_match;
      logic v_done;
      logic have_star;
      logic p_star;
      logic p_query;
      logic p_open;
      logic p_close;
      logic p_zero;
      logic p_bang_caret;
      logic p_dash;
      logic p_eq_c;
      logic c_open;
      logic cls_hit;
   } status_type;

endpackage

[src/gpm_ctrl.sv]
module gpm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2:0]          action,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  gpm_pkg::status_type status,
   output gpm_pkg::cmd_type    cmd
);
   import gpm_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_FETCH  = 14'b00000000000010,
      S_DECIDE = 14'b00000000000100,
      S_TAIL   = 14'b00000000001000,
      S_CINV_F = 14'b00000000010000,
      S_CINV   = 14'b00000000100000,
      S_CCL_F  = 14'b00000001000000,
      S_CCL    = 14'b00000010000000,
      S_CLO_F  = 14'b00000100000000,
      S_CLO    = 14'b00001000000000,
      S_CD_F   = 14'b00010000000000,
      S_CD     = 14'b00100000000000,
      S_CHI_F  = 14'b01000000000000,
      S_CHI    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      cmd.psel = PSEL_PI;
      cmd.res  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               case (action_type'(action))
                  ACT_NEW_PATTERN, ACT_PATTERN_BYTE, ACT_PATTERN_ABSENT, ACT_VALUE_BYTE: begin
                     cmd.op = OP_LOAD;
                  end
                  ACT_EVALUATE, ACT_EVALUATE_ABSENT: begin
                     if (status.quick) begin
                        cmd.op  = OP_RESULT;
                        cmd.res = status.quick_match;
                     end else begin
                        cmd.op   = OP_EVAL_START;
                        state_in = S_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            cmd.psel = PSEL_PI;
            state_in = status.v_done ? S_TAIL : S_DECIDE;
         end
         S_TAIL: begin
            if (status.p_star) begin
               cmd.op   = OP_SKIP;
               state_in = S_FETCH;
            end else begin
               cmd.op   = OP_RESULT;
               cmd.res  = status.p_zero;
               state_in = S_IDLE;
            end
         end
         S_DECIDE: begin
            if (status.p_star) begin
               cmd.op   = OP_STAR;
               state_in = S_FETCH;
            end else if (status.p_query) begin
               cmd.op   = OP_ADV;
               state_in = S_FETCH;
            end else if (status.p_open) begin
               cmd.op   = OP_CLS_START;
               state_in = S_CINV_F;
            end else if (status.p_eq_c) begin
               cmd.op   = OP_ADV;
               state_in = S_FETCH;
            end else if (status.have_star) begin
               cmd.op   = OP_BACK;
               state_in = S_FETCH;
            end else begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         S_CINV_F: begin
            cmd.psel = PSEL_CI;
            state_in = S_CINV;
         end
         S_CINV: begin
            if (status.p_bang_caret) begin
               cmd.op = OP_CLS_INV;
            end
            state_in = S_CCL_F;
         end
         S_CCL_F: begin
            cmd.psel = PSEL_CI;
            state_in = S_CCL;
         end
         S_CCL: begin
            if (status.p_close) begin
               cmd.op = OP_CLS_CLOSE;
            end
            state_in = S_CLO_F;
         end
         S_CLO_F: begin
            cmd.psel = PSEL_CI;
            state_in = S_CLO;
         end
         S_CLO: begin
            if (status.p_close && status.cls_hit) begin
               cmd.op   = OP_CLS_TAKE;
               state_in = S_FETCH;
            end else if (status.p_zero && status.c_open) begin
               cmd.op   = OP_CLS_LIT;
               state_in = S_FETCH;
            end else if (status.p_close || status.p_zero) begin
               if (status.have_star) begin
                  cmd.op   = OP_BACK;
                  state_in = S_FETCH;
               end else begin
                  cmd.op   = OP_RESULT;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.op   = OP_CLS_LO;
               state_in = S_CD_F;
            end
         end
         S_CD_F: begin
            cmd.psel = PSEL_CI1;
            state_in = S_CD;
         end
         S_CD: begin
            if (status.p_dash) begin
               state_in = S_CHI_F;
            end else begin
               cmd.op   = OP_CLS_SINGLE;
               state_in = S_CLO_F;
            end
         end
         S_CHI_F: begin
            cmd.psel = PSEL_CI2;
            state_in = S_CHI;
         end
         S_CHI: begin
            if (!status.p_zero && !status.p_close) begin
               cmd.op = OP_CLS_RANGE;
            end else begin
               cmd.op = OP_CLS_SINGLE;
            end
            state_in = S_CLO_F;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.op == OP_RESULT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/gpm_dp.sv]
module gpm_dp #(
   parameter int PATTERN_DEPTH = 64,
   parameter int VALUE_DEPTH   = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          action,
   input  logic [7:0]          data_byte,
   input  gpm_pkg::cmd_type    cmd,
   output gpm_pkg::status_type status,
   output logic                matched,
   output logic                overflowed
);
   import gpm_pkg::*;

   localparam int PA  = $clog2(PATTERN_DEPTH);
   localparam int PLW = $clog2(PATTERN_DEPTH + 1);
   localparam int PIW = $clog2(PATTERN_DEPTH + 3);
   localparam int VA  = $clog2(VALUE_DEPTH);
   localparam int VIW = $clog2(VALUE_DEPTH + 1);
   localparam logic [PLW-1:0] PLEN_MAX = PLW'(PATTERN_DEPTH);
   localparam logic [VIW-1:0] VLEN_MAX = VIW'(VALUE_DEPTH);

   logic [7:0] pattern_mem [PATTERN_DEPTH];
   logic [7:0] value_mem   [VALUE_DEPTH];

   logic [PLW-1:0] plen_ff, plen_in;
   logic [VIW-1:0] vlen_ff, vlen_in;
   logic           missing_ff, missing_in;
   logic           ovf_ff, ovf_in;
   logic [PIW-1:0] pi_ff, pi_in;
   logic [PIW-1:0] star_p_ff, star_p_in;
   logic [PIW-1:0] ci_ff, ci_in;
   logic [PIW-1:0] start_ff, start_in;
   logic [VIW-1:0] vi_ff, vi_in;
   logic [VIW-1:0] star_v_ff, star_v_in;
   logic           have_star_ff, have_star_in;
   logic           inv_ff, inv_in;
   logic           hit_ff, hit_in;
   logic [7:0]     lo_ff, lo_in;
   logic           matched_ff, matched_in;
   logic           overflowed_ff, overflowed_in;
   logic [7:0]     prd_ff;
   logic           p_ok_ff;
   logic [7:0]     vrd_ff;

   logic [PIW-1:0] paddr;
   logic [7:0]     pbyte;
   logic           pwe;
   logic           vwe;

   always_comb begin
      case (cmd.psel)
         PSEL_PI:  paddr = pi_ff;
         PSEL_CI:  paddr = ci_ff;
         PSEL_CI1: paddr = ci_ff + PIW'(1);
         PSEL_CI2: paddr = ci_ff + PIW'(2);
         default:  paddr = pi_ff;
      endcase
   end

   assign pbyte = p_ok_ff ? prd_ff : 8'h00;

   assign status.quick        = ovf_ff || missing_ff ||
                                (action == ACT_EVALUATE_ABSENT);
   assign status.quick_match  = !ovf_ff && missing_ff;
   assign status.v_done       = vi_ff >= vlen_ff;
   assign status.have_star    = have_star_ff;
   assign status.p_star       = pbyte == CH_STAR;
   assign status.p_query      = pbyte == CH_QUERY;
   assign status.p_open       = pbyte == CH_OPEN;
   assign status.p_close      = pbyte == CH_CLOSE;
   assign status.p_zero       = pbyte == 8'h00;
   assign status.p_bang_caret = (pbyte == CH_BANG) || (pbyte == CH_CARET);
   assign status.p_dash       = pbyte == CH_DASH;
   assign status.p_eq_c       = pbyte == vrd_ff;
   assign status.c_open       = vrd_ff == CH_OPEN;
   assign status.cls_hit      = hit_ff ^ inv_ff;

   assign matched    = matched_ff;
   assign overflowed = overflowed_ff;

   always_comb begin
      plen_in       = plen_ff;
      vlen_in       = vlen_ff;
      missing_in    = missing_ff;
      ovf_in        = ovf_ff;
      pi_in         = pi_ff;
      star_p_in     = star_p_ff;
      ci_in         = ci_ff;
      start_in      = start_ff;
      vi_in         = vi_ff;
      star_v_in     = star_v_ff;
      have_star_in  = have_star_ff;
      inv_in        = inv_ff;
      hit_in        = hit_ff;
      lo_in         = lo_ff;
      matched_in    = matched_ff;
      overflowed_in = overflowed_ff;
      pwe           = 1'b0;
      vwe           = 1'b0;
      case (cmd.op)
         OP_LOAD: begin
            case (action_type'(action))
               ACT_NEW_PATTERN, ACT_PATTERN_ABSENT: begin
                  plen_in    = '0;
                  vlen_in    = '0;
                  ovf_in     = 1'b0;
                  missing_in = action == ACT_PATTERN_ABSENT;
               end
               ACT_PATTERN_BYTE: begin
                  if (data_byte != 8'h00) begin
                     missing_in = 1'b0;
                     if (plen_ff < PLEN_MAX) begin
                        pwe     = 1'b1;
                        plen_in = plen_ff + PLW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
               end
               ACT_VALUE_BYTE: begin
                  if (data_byte != 8'h00) begin
                     if (vlen_ff < VLEN_MAX) begin
                        vwe     = 1'b1;
                        vlen_in = vlen_ff + VIW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
         OP_EVAL_START: begin
            pi_in        = '0;
            vi_in        = '0;
            have_star_in = 1'b0;
         end
         OP_STAR: begin
            pi_in        = pi_ff + PIW'(1);
            star_p_in    = pi_ff + PIW'(1);
            star_v_in    = vi_ff;
            have_star_in = 1'b1;
         end
         OP_ADV: begin
            pi_in = pi_ff + PIW'(1);
            vi_in = vi_ff + VIW'(1);
         end
         OP_BACK: begin
            pi_in     = star_p_ff;
            star_v_in = star_v_ff + VIW'(1);
            vi_in     = star_v_ff + VIW'(1);
         end
         OP_SKIP: begin
            pi_in = pi_ff + PIW'(1);
         end
         OP_RESULT: begin
            matched_in    = cmd.res;
            overflowed_in = ovf_ff;
            vlen_in       = '0;
         end
         OP_CLS_START: begin
            start_in = pi_ff;
            ci_in    = pi_ff + PIW'(1);
            inv_in   = 1'b0;
            hit_in   = 1'b0;
         end
         OP_CLS_INV: begin
            inv_in = 1'b1;
            ci_in  = ci_ff + PIW'(1);
         end
         OP_CLS_CLOSE: begin
            hit_in = hit_ff || (vrd_ff == CH_CLOSE);
            ci_in  = ci_ff + PIW'(1);
         end
         OP_CLS_LO: begin
            lo_in = pbyte;
         end
         OP_CLS_SINGLE: begin
            hit_in = hit_ff || (lo_ff == vrd_ff);
            ci_in  = ci_ff + PIW'(1);
         end
         OP_CLS_RANGE: begin
            hit_in = hit_ff || ((lo_ff <= vrd_ff) && (vrd_ff <= pbyte));
            ci_in  = ci_ff + PIW'(3);
         end
         OP_CLS_TAKE: begin
            pi_in = ci_ff + PIW'(1);
            vi_in = vi_ff + VIW'(1);
         end
         OP_CLS_LIT: begin
            pi_in = start_ff + PIW'(1);
            vi_in = vi_ff + VIW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pwe) begin
         pattern_mem[plen_ff[PA-1:0]] <= data_byte;
      end
      prd_ff  <= pattern_mem[paddr[PA-1:0]];
      p_ok_ff <= paddr < PIW'(plen_ff);
   end

   always_ff @(posedge clock) begin
      if (vwe) begin
         value_mem[vlen_ff[VA-1:0]] <= data_byte;
      end
      vrd_ff <= value_mem[vi_ff[VA-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff    <= '0;
         vlen_ff    <= '0;
         missing_ff <= 1'b1;
         ovf_ff     <= 1'b0;
      end else begin
         plen_ff    <= plen_in;
         vlen_ff    <= vlen_in;
         missing_ff <= missing_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      pi_ff         <= pi_in;
      star_p_ff     <= star_p_in;
      ci_ff         <= ci_in;
      start_ff      <= start_in;
      vi_ff         <= vi_in;
      star_v_ff     <= star_v_in;
      have_star_ff  <= have_star_in;
      inv_ff        <= inv_in;
      hit_ff        <= hit_in;
      lo_ff         <= lo_in;
      matched_ff    <= matched_in;
      overflowed_ff <= overflowed_in;
   end

endmodule

[src/glob_pattern_matcher.sv]
// Glob matcher: load a pattern and a value one byte per item, then evaluate.
// Load items, pattern-absent and value-absent evaluations, and evaluations
// under overflow are handled in the idle state without a walk. A full evaluation
// walks the pattern and value memories, each through its own registered read
// port: every pattern/value step or star is a fetch state and then a decide
// state, each bracket byte inspected is fetched and then checked (a range end
// adds its own fetch and check), and a backtrack to the last star repeats the
// walk from there. No input item is taken while an evaluation runs; a new item
// is taken while a finished result waits only if that result is taken the
// same cycle.
module glob_pattern_matcher #(
   parameter int PATTERN_DEPTH = 64,
   parameter int VALUE_DEPTH   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // action[2:0], data_byte[10:3], zero[15:11]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // matched[0], overflowed[1], zero[7:2]
);
   import gpm_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       matched;
   logic       overflowed;

   gpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tdata[2:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gpm_dp #(
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .VALUE_DEPTH   (VALUE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .action     (req_tdata[2:0]),
      .data_byte  (req_tdata[10:3]),
      .cmd        (cmd),
      .status     (status),
      .matched    (matched),
      .overflowed (overflowed)
   );

   assign rsp_tdata = {6'b000000, overflowed, matched};

endmodule

[src/gpm_checker.sv]
module gpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);
   import gpm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid &&
      req_tdata[2:0] != ACT_EVALUATE && req_tdata[2:0] != ACT_EVALUATE_ABSENT
      |=> !rsp_tvalid)
      else $error("result item without an evaluation");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:2] == 6'b000000)
      else $error("result padding not zero");

   a_ovf_nomatch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("match reported with overflow");

endmodule

bind glob_pattern_matcher gpm_checker u_gpm_checker (.*);

[bench/tb_glob_pattern_matcher.sv]
`timescale 1ns / 1ps

module tb_glob_pattern_matcher;
   import gpm_pkg::*;

   localparam int PAT_DEPTH = 64;
   localparam int VAL_DEPTH = 256;
   localparam int ITEM_TARGET = 1925;
   localparam int STALL_LIMIT = 200000;
   localparam int TAIL_CYCLES = 40;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   typedef struct packed {
      logic overflowed;
      logic matched;
   } verdict_type;

   class match_ledger;
      logic [7:0] pat [PAT_DEPTH];
      logic [7:0] val [VAL_DEPTH];
      int         pat_len = 0;
      int         val_len = 0;
      bit         pat_missing = 1'b1;
      bit         ovf = 1'b0;
      verdict_type due_verdicts[$];
      int         errors = 0;
      int         verdicts_seen = 0;
      int         hits = 0;
      int         ovf_seen = 0;

      function logic [7:0] pat_at(int i);
         return (i < pat_len) ? pat[i] : 8'h00;
      endfunction

      function bit bracket_hits(int start, logic [7:0] c, output int used);
         int         i;
         bit         inv;
         bit         hit;
         logic [7:0] lo;
         i = start + 1;
         inv = 1'b0;
         hit = 1'b0;
         if (pat_at(i) == CH_BANG || pat_at(i) == CH_CARET) begin
            inv = 1'b1;
            i++;
         end
         if (pat_at(i) == CH_CLOSE) begin
            if (c == CH_CLOSE) hit = 1'b1;
            i++;
         end
         while (pat_at(i) != 8'h00 && pat_at(i) != CH_CLOSE) begin
            lo = pat_at(i);
            if (pat_at(i + 1) == CH_DASH && pat_at(i + 2) != 8'h00 &&
                pat_at(i + 2) != CH_CLOSE) begin
               if (lo <= c && c <= pat_at(i + 2)) hit = 1'b1;
               i += 3;
            end else begin
               if (lo == c) hit = 1'b1;
               i++;
            end
         end
         if (pat_at(i) != CH_CLOSE) begin
            used = 1;
            return c == CH_OPEN;
         end
         used = i + 1 - start;
         return inv ? !hit : hit;
      endfunction

      function bit glob_matches();
         int         pi;
         int         vi;
         int         star_p;
         int         star_v;
         int         used;
         bit         have_star;
         logic [7:0] p;
         logic [7:0] c;
         pi = 0;
         vi = 0;
         star_p = 0;
         star_v = 0;
         used = 0;
         have_star = 1'b0;
         while (vi < val_len) begin
            p = pat_at(pi);
            c = val[vi];
            if (p == CH_STAR) begin
               while (pat_at(pi) == CH_STAR) pi++;
               star_p = pi;
               star_v = vi;
               have_star = 1'b1;
            end else if (p == CH_QUERY || (p != CH_OPEN && p == c)) begin
               pi++;
               vi++;
            end else if (p == CH_OPEN && bracket_hits(pi, c, used)) begin
               pi += used;
               vi++;
            end else if (have_star) begin
               pi = star_p;
               star_v++;
               vi = star_v;
            end else begin
               return 1'b0;
            end
         end
         while (pat_at(pi) == CH_STAR) pi++;
         return pat_at(pi) == 8'h00;
      endfunction

      function void note_item(logic [2:0] code, logic [7:0] data);
         verdict_type v;
         case (code)
            ACT_NEW_PATTERN, ACT_PATTERN_ABSENT: begin
               pat_len = 0;
               pat_missing = (code == ACT_PATTERN_ABSENT);
               val_len = 0;
               ovf = 1'b0;
            end
            ACT_PATTERN_BYTE: if (data != 8'h00) begin
               pat_missing = 1'b0;
               if (pat_len < PAT_DEPTH) pat[pat_len++] = data;
               else ovf = 1'b1;
            end
            ACT_VALUE_BYTE: if (data != 8'h00) begin
               if (val_len < VAL_DEPTH) val[val_len++] = data;
               else ovf = 1'b1;
            end
            ACT_EVALUATE, ACT_EVALUATE_ABSENT: begin
               v.overflowed = ovf;
               if (ovf) v.matched = 1'b0;
               else if (pat_missing) v.matched = 1'b1;
               else if (code == ACT_EVALUATE_ABSENT) v.matched = 1'b0;
               else v.matched = glob_matches();
               due_verdicts.push_back(v);
               val_len = 0;
            end
            default: ;
         endcase
      endfunction

      function void check_verdict(logic matched, logic overflowed);
         verdict_type want;
         if (due_verdicts.size() == 0) begin
            $error("unexpected result: matched=%0b overflowed=%0b", matched, overflowed);
            errors++;
            return;
         end
         want = due_verdicts.pop_front();
         verdicts_seen++;
         if (matched === 1'b1) hits++;
         if (overflowed === 1'b1) ovf_seen++;
         if (matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, matched);
            errors++;
         end
         if (overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, got %0b", want.overflowed, overflowed);
            errors++;
         end
      endfunction

      function int pending();
         return due_verdicts.size();
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'h0000;   // action[2:0], data_byte[10:3], zero[15:11]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;              // matched[0], overflowed[1], zero[7:2]

   match_ledger book = new();
   int          items_sent = 0;
   int          quiet = 0;
   bit          steady = 1'b0;

   glob_pattern_matcher #(
      .PATTERN_DEPTH(PAT_DEPTH),
      .VALUE_DEPTH  (VAL_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] glob_byte();
      case ($urandom_range(0, 19))
         0, 1:    return CH_STAR;
         2:       return CH_QUERY;
         3, 4:    return CH_OPEN;
         5:       return CH_CLOSE;
         6:       return CH_BANG;
         7:       return CH_CARET;
         8:       return CH_DASH;
         9:       return 8'($urandom_range(1, 255));
         default: return 8'("a" + $urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [7:0] value_byte();
      if ($urandom_range(0, 7) == 0) return glob_byte();
      return 8'("a" + $urandom_range(0, 3));
   endfunction

   task automatic send_item(logic [2:0] act, logic [7:0] data);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b00000, data, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_item(act, data);
      if (!(act == ACT_SPARE_6 || act == ACT_SPARE_7 ||
            ((act == ACT_PATTERN_BYTE || act == ACT_VALUE_BYTE) && data == 8'h00)))
         items_sent++;
      steady = (items_sent >= 700 && items_sent < 1000);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic run_session();
      logic [7:0] pat_q[$];
      logic [7:0] val_q[$];
      logic [7:0] b;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(4, 12))
            send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 11) == 0) begin
         send_item(ACT_PATTERN_ABSENT, 8'($urandom_range(0, 255)));
      end else begin
         send_item(ACT_NEW_PATTERN, 8'($urandom_range(0, 255)));
         repeat ($urandom_range(0, 10)) begin
            b = glob_byte();
            pat_q.push_back(b);
            send_item(ACT_PATTERN_BYTE, b);
         end
      end
      repeat ($urandom_range(1, 4)) begin
         val_q.delete();
         if ($urandom_range(0, 1)) begin
            foreach (pat_q[i]) begin
               case (pat_q[i])
                  CH_STAR:          repeat ($urandom_range(0, 2)) val_q.push_back(value_byte());
                  CH_QUERY, CH_OPEN: val_q.push_back(value_byte());
                  default:          val_q.push_back(pat_q[i]);
               endcase
            end
         end else begin
            repeat ($urandom_range(0, 10)) val_q.push_back(value_byte());
         end
         foreach (val_q[i]) begin
            if ($urandom_range(0, 29) == 0) send_item(ACT_VALUE_BYTE, 8'h00);
            send_item(ACT_VALUE_BYTE, val_q[i]);
         end
         send_item($urandom_range(0, 9) == 0 ? ACT_EVALUATE_ABSENT : ACT_EVALUATE,
                   8'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_long(int kind);
      logic [7:0] pat_q[$];
      logic [7:0] b;
      send_item(ACT_NEW_PATTERN, 8'h00);
      case (kind)
         0: begin
            repeat (PAT_DEPTH + $urandom_range(1, 4))
               send_item(ACT_PATTERN_BYTE, $urandom_range(0, 1) ? CH_QUERY : value_byte());
            repeat (3) send_item(ACT_VALUE_BYTE, value_byte());
            send_item(ACT_EVALUATE, 8'h00);
            repeat (2) send_item(ACT_VALUE_BYTE, value_byte());
            send_item(ACT_EVALUATE, 8'h00);
         end
         1: begin
            repeat (PAT_DEPTH) begin
               b = $urandom_range(0, 1) ? CH_QUERY : 8'("a" + $urandom_range(0, 3));
               pat_q.push_back(b);
               send_item(ACT_PATTERN_BYTE, b);
            end
            foreach (pat_q[i])
               send_item(ACT_VALUE_BYTE, pat_q[i] == CH_QUERY ? value_byte() : pat_q[i]);
            send_item(ACT_EVALUATE, 8'h00);
            send_item(ACT_EVALUATE_ABSENT, 8'h00);
         end
         2: begin
            send_item(ACT_PATTERN_BYTE, CH_STAR);
            repeat (VAL_DEPTH + $urandom_range(1, 3)) send_item(ACT_VALUE_BYTE, value_byte());
            send_item(ACT_EVALUATE, 8'h00);
            send_item(ACT_EVALUATE, 8'h00);
         end
         default: begin
            send_item(ACT_PATTERN_BYTE, CH_QUERY);
            send_item(ACT_PATTERN_BYTE, CH_STAR);
            send_item(ACT_PATTERN_BYTE, "a");
            repeat (VAL_DEPTH - 1) send_item(ACT_VALUE_BYTE, value_byte());
            send_item(ACT_VALUE_BYTE, "a");
            send_item(ACT_EVALUATE, 8'h00);
         end
      endcase
   endtask

   initial begin
      int hold;
      bit held;
      hold = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && book.verdicts_seen >= 120) begin
            held = 1'b1;
            hold = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 28);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_verdict(rsp_tdata[0], rsp_tdata[1]);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= STALL_LIMIT) begin
         $display("glob_pattern_matcher test failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int session;
      session = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_item(ACT_EVALUATE, 8'h00);
      send_item(ACT_VALUE_BYTE, 8'hFF);
      send_item(ACT_EVALUATE_ABSENT, 8'hFF);
      send_item(ACT_NEW_PATTERN, 8'h00);
      send_item(ACT_EVALUATE, 8'h00);
      send_item(ACT_PATTERN_BYTE, 8'h00);
      send_item(ACT_PATTERN_BYTE, CH_STAR);
      send_item(ACT_PATTERN_BYTE, CH_STAR);
      send_item(ACT_EVALUATE, 8'h00);
      send_item(ACT_EVALUATE_ABSENT, 8'h00);
      send_item(ACT_PATTERN_ABSENT, 8'h00);
      send_item(ACT_SPARE_6, 8'hFF);
      send_item(ACT_SPARE_7, 8'hA5);
      send_item(ACT_NEW_PATTERN, 8'h00);
      send_item(ACT_PATTERN_BYTE, CH_OPEN);
      send_item(ACT_PATTERN_BYTE, CH_BANG);
      send_item(ACT_PATTERN_BYTE, CH_CLOSE);
      send_item(ACT_PATTERN_BYTE, "a");
      send_item(ACT_PATTERN_BYTE, CH_DASH);
      send_item(ACT_PATTERN_BYTE, "c");
      send_item(ACT_PATTERN_BYTE, CH_CLOSE);
      send_item(ACT_PATTERN_BYTE, CH_QUERY);
      send_item(ACT_PATTERN_BYTE, CH_OPEN);
      send_item(ACT_PATTERN_BYTE, CH_STAR);
      send_item(ACT_VALUE_BYTE, "x");
      send_item(ACT_VALUE_BYTE, 8'hFF);
      send_item(ACT_VALUE_BYTE, CH_OPEN);
      send_item(ACT_EVALUATE, 8'h00);

      while (items_sent < ITEM_TARGET) begin
         if (session % 20 == 5) run_long((session / 20) % 4);
         else run_session();
         if (session % 30 == 29) drain_results();
         session++;
      end
      drain_results();

      $display("%0d items loaded or evaluated in %0d sessions", items_sent, session);
      $display("%0d verdicts checked: %0d matches, %0d with overflow",
               book.verdicts_seen, book.hits, book.ovf_seen);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("glob_pattern_matcher test passed");
      end else begin
         $display("glob_pattern_matcher test failed");
      end
      $finish;
   end

endmodule

[glob_pattern_matcher.f]
src/gpm_pkg.sv
src/gpm_ctrl.sv
src/gpm_dp.sv
src/glob_pattern_matcher.sv
src/gpm_checker.sv
bench/tb_glob_pattern_matcher.sv
